@@ design/rtd_block_average_fault_vote_assert.svh @@
// assertion macros for the rtd block average fault vote design
`ifndef RTD_BLOCK_AVERAGE_FAULT_VOTE_ASSERT_SVH
`define RTD_BLOCK_AVERAGE_FAULT_VOTE_ASSERT_SVH

`ifndef SYNTHESIS
`define RBAFV_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m check failed");
`define RBAFV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m check failed");
`else
`define RBAFV_ASSERT(label, ante, cons)
`define RBAFV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/rtdbafv_pkg.sv @@
// shared types and constants for the rtd block average fault vote design
package rtdbafv_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned VOTE_W     = 4;
    localparam int unsigned MASK_W     = 3;
    localparam int unsigned NFLAGS     = 3;
    localparam int unsigned FLAG_OPEN  = 0;
    localparam int unsigned FLAG_SHORT = 1;
    localparam int unsigned FLAG_HOT   = 2;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic signed [DATA_W-1:0] OVERHEAT_RST = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] OPEN_RST     = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] SHORT_RST    = 16'sh8000;
    localparam logic [VOTE_W-1:0]        VOTES_RST    = 4'd4;

    typedef enum logic [1:0] {
        REG_OVERHEAT_LIMIT = 2'd0,
        REG_OPEN_CODE      = 2'd1,
        REG_SHORT_CODE     = 2'd2,
        REG_FAULT_VOTES    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] overheat_limit;
        logic signed [DATA_W-1:0] open_code;
        logic signed [DATA_W-1:0] short_code;
        logic [VOTE_W-1:0]        fault_votes;
    } t_cfg;

endpackage

@@ design/rtd_block_average_fault_vote.sv @@
// rtd block average with fault vote: top level
// Takes one temperature beat per clock unless the result side stalls, and returns one result
// beat per input beat. Acceptance shifts the sample into a line of RING_DEPTH registers
// (cleared at reset, so no start-up pass), updates a running sum and compares every entry with
// the two fault codes; the vote stage counts the fault votes and multiplies the sum magnitude
// by a constant reciprocal of RING_DEPTH; the product stage picks the temperature, checks the
// overheat limit and updates the sticky flags. Every RING_DEPTH-th beat, starting with the
// first after reset, reports a fresh evaluation; the others repeat the held temperature.
// Configuration writes over the apb port must only be made while no beat is in flight.
`include "rtd_block_average_fault_vote_assert.svh"

module rtd_block_average_fault_vote import rtdbafv_pkg::*; #(
    parameter int unsigned RING_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample[15:0], clear_mask[18:16], zero[23:19]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // temperature[15:0], evaluated[16], open_flag[17], shorted_flag[18], overheat_flag[19],
    // new_open[20], new_short[21], new_overheat[22], zero[23]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned PTR_W   = $clog2(RING_DEPTH);
    localparam int unsigned SUM_W   = DATA_W + PTR_W;
    localparam int unsigned SHIFT   = SUM_W + PTR_W;
    localparam int unsigned RECIP_W = SUM_W + 1;
    localparam int unsigned PROD_W  = SUM_W + RECIP_W;
    localparam int unsigned QUO_W   = DATA_W + 1;
    localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int unsigned CMP_W   = (CNT_W > VOTE_W) ? CNT_W : VOTE_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(RING_DEPTH - 1);

    t_cfg cfg;

    rtdbafv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake and stage flow
    logic s_acc;
    logic out_free;
    logic s1_free;
    logic s1_move;
    logic s2_free;
    logic s2_move;

    // ring and running sum
    logic signed [DATA_W-1:0] in_sample;
    logic [MASK_W-1:0]        in_mask;
    logic signed [DATA_W-1:0] ring_in [RING_DEPTH];
    logic signed [DATA_W-1:0] r_ring  [RING_DEPTH];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic [PTR_W-1:0]         r_ptr;
    logic [RING_DEPTH-1:0]    n_open_hits;
    logic [RING_DEPTH-1:0]    n_short_hits;

    // vote stage
    logic                     r_s1_valid;
    logic                     r_s1_eval;
    logic [MASK_W-1:0]        r_s1_mask;
    logic signed [SUM_W-1:0]  r_s1_sum;
    logic [RING_DEPTH-1:0]    r_s1_open_hits;
    logic [RING_DEPTH-1:0]    r_s1_short_hits;
    logic [CNT_W-1:0]         open_cnt;
    logic [CNT_W-1:0]         short_cnt;
    logic                     s1_open;
    logic                     s1_short;
    logic [SUM_W-1:0]         s1_mag;
    logic [PROD_W-1:0]        s1_prod;

    // product stage
    logic                     r_s2_valid;
    logic                     r_s2_eval;
    logic [MASK_W-1:0]        r_s2_mask;
    logic                     r_s2_neg;
    logic                     r_s2_open;
    logic                     r_s2_short;
    logic [PROD_W-1:0]        r_s2_prod;
    logic [QUO_W-1:0]         s2_quo;
    logic [QUO_W-1:0]         s2_avg_w;
    logic signed [DATA_W-1:0] s2_avg;
    logic [NFLAGS-1:0]        s2_before;

    // held result
    logic                     r_out_valid;
    logic                     r_out_eval;
    logic signed [DATA_W-1:0] r_held;
    logic signed [DATA_W-1:0] n_held;
    logic [NFLAGS-1:0]        r_flags;
    logic [NFLAGS-1:0]        n_flags;
    logic [NFLAGS-1:0]        r_new;
    logic [NFLAGS-1:0]        n_new;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s2_move       = r_s2_valid && out_free;
    assign s2_free       = !r_s2_valid || out_free;
    assign s1_move       = r_s1_valid && s2_free;
    assign s1_free       = !r_s1_valid || s2_free;
    assign s_axis_tready = s1_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign in_sample = s_axis_tdata[DATA_W-1:0];
    assign in_mask   = s_axis_tdata[DATA_W+MASK_W-1:DATA_W];

    always_comb begin
        ring_in[0] = in_sample;
        for (int i = 1; i < RING_DEPTH; i++) begin
            ring_in[i] = r_ring[i-1];
        end
        for (int i = 0; i < RING_DEPTH; i++) begin
            n_open_hits[i]  = (ring_in[i] == cfg.open_code);
            n_short_hits[i] = (ring_in[i] == cfg.short_code);
        end
    end

    assign n_sum = r_sum + SUM_W'(in_sample) - SUM_W'(r_ring[RING_DEPTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_sum <= '0;
            r_ptr <= '0;
        end else if (s_acc) begin
            r_ring <= ring_in;
            r_sum  <= n_sum;
            r_ptr  <= (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_eval       <= (r_ptr == '0);
            r_s1_mask       <= in_mask;
            r_s1_sum        <= n_sum;
            r_s1_open_hits  <= n_open_hits;
            r_s1_short_hits <= n_short_hits;
        end
    end

    // vote count and reciprocal multiply
    assign open_cnt  = CNT_W'($countones(r_s1_open_hits));
    assign short_cnt = CNT_W'($countones(r_s1_short_hits));
    assign s1_open   = CMP_W'(open_cnt) >= CMP_W'(cfg.fault_votes);
    assign s1_short  = CMP_W'(short_cnt) >= CMP_W'(cfg.fault_votes);
    assign s1_mag    = r_s1_sum[SUM_W-1] ? SUM_W'(-r_s1_sum) : SUM_W'(r_s1_sum);
    assign s1_prod   = PROD_W'(s1_mag) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_eval  <= r_s1_eval;
            r_s2_mask  <= r_s1_mask;
            r_s2_neg   <= r_s1_sum[SUM_W-1];
            r_s2_open  <= s1_open;
            r_s2_short <= s1_short;
            r_s2_prod  <= s1_prod;
        end
    end

    // truncate toward zero: divide the magnitude, then restore the sign
    assign s2_quo    = r_s2_prod[SHIFT +: QUO_W];
    assign s2_avg_w  = r_s2_neg ? (QUO_W'(0) - s2_quo) : s2_quo;
    assign s2_avg    = s2_avg_w[DATA_W-1:0];
    assign s2_before = r_flags & ~r_s2_mask;

    always_comb begin
        n_held  = r_held;
        n_flags = s2_before;
        if (r_s2_eval) begin
            if (!r_s2_open && !r_s2_short) begin
                n_held = s2_avg;
            end
            if (r_s2_open) begin
                n_held             = cfg.open_code;
                n_flags[FLAG_OPEN] = 1'b1;
            end
            if (r_s2_short) begin
                n_held              = cfg.short_code;
                n_flags[FLAG_SHORT] = 1'b1;
            end
            if (n_held > cfg.overheat_limit) begin
                n_flags[FLAG_HOT] = 1'b1;
            end
        end
        n_new = n_flags & ~s2_before;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_eval  <= 1'b0;
            r_held      <= '0;
            r_flags     <= '0;
            r_new       <= '0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
            r_out_eval  <= r_s2_eval;
            r_held      <= n_held;
            r_flags     <= n_flags;
            r_new       <= n_new;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0,
                            r_new[FLAG_HOT], r_new[FLAG_SHORT], r_new[FLAG_OPEN],
                            r_flags[FLAG_HOT], r_flags[FLAG_SHORT], r_flags[FLAG_OPEN],
                            r_out_eval, r_held};

    `RBAFV_ASSERT_NEXT(a_ptr_wrap, s_acc && (r_ptr == PTR_LAST), r_ptr == '0)
    `RBAFV_ASSERT(a_pulse_needs_eval, r_out_valid && (r_new != '0), r_out_eval)
    `RBAFV_ASSERT(a_pulse_has_flag, r_out_valid, (r_new & ~r_flags) == '0)
    `RBAFV_ASSERT_NEXT(a_s1_held, r_s1_valid && !s2_free, r_s1_valid && $stable(r_s1_sum))
    `RBAFV_ASSERT_NEXT(a_short_wins, s2_move && r_s2_eval && r_s2_short,
                       r_held == $past(cfg.short_code))

endmodule

@@ design/rtdbafv_cfg.sv @@
// apb register file holding the limit, fault codes and vote count
module rtdbafv_cfg import rtdbafv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_OVERHEAT_LIMIT: n_cfg.overheat_limit = pwdata[DATA_W-1:0];
                REG_OPEN_CODE:      n_cfg.open_code      = pwdata[DATA_W-1:0];
                REG_SHORT_CODE:     n_cfg.short_code     = pwdata[DATA_W-1:0];
                REG_FAULT_VOTES:    n_cfg.fault_votes    = pwdata[VOTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overheat_limit <= OVERHEAT_RST;
            r_cfg.open_code      <= OPEN_RST;
            r_cfg.short_code     <= SHORT_RST;
            r_cfg.fault_votes    <= VOTES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OVERHEAT_LIMIT: prdata = {{(CFG_DATA_W-DATA_W){r_cfg.overheat_limit[DATA_W-1]}},
                                          r_cfg.overheat_limit};
            REG_OPEN_CODE:      prdata = {{(CFG_DATA_W-DATA_W){r_cfg.open_code[DATA_W-1]}},
                                          r_cfg.open_code};
            REG_SHORT_CODE:     prdata = {{(CFG_DATA_W-DATA_W){r_cfg.short_code[DATA_W-1]}},
                                          r_cfg.short_code};
            REG_FAULT_VOTES:    prdata = {{(CFG_DATA_W-VOTE_W){1'b0}}, r_cfg.fault_votes};
            default:            prdata = '0;
        endcase
    end

endmodule

@@ bench/rtd_block_average_fault_vote_tb.sv @@
// self-checking testbench for the rtd block average fault vote block: directed table, then random beats
module rtd_block_average_fault_vote_tb import rtdbafv_pkg::*; ;

    localparam int RING          = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int FILL_HOLD     = 80;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 75;

    // temperature[15:0], evaluated[16], open/short/overheat flags[19:17], new pulses[22:20]
    typedef struct packed {
        logic [NFLAGS-1:0]        fresh;
        logic [NFLAGS-1:0]        sticky;
        logic                     evaluated;
        logic signed [DATA_W-1:0] temperature;
    } t_reading;

    typedef enum logic {
        ROW_BEAT,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_reg_idx    reg_idx;
        logic [15:0] value;
        logic [2:0]  mask;
        bit          typed;
        t_reading    want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample[15:0], clear_mask[18:16], zero[23:19]
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // temperature[15:0], evaluated[16], flags[19:17], new pulses[22:20], zero[23]
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    rtd_block_average_fault_vote #(
        .RING_DEPTH(RING)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [DATA_W-1:0] ring_copy [RING];
    int                       slot;
    logic signed [DATA_W-1:0] held_temp;
    logic [NFLAGS-1:0]        sticky_copy;
    t_cfg                     shadow_cfg;

    t_reading    pending_readings [$];
    t_script_row script [$];
    bit          quiet = 1'b0;
    bit          fill_hold = 1'b0;
    int          rx_hold = 0;
    int          rx_gap;
    int          mismatches = 0;
    int          cycles = 0;
    t_reading    rx_got;
    t_reading    rx_want;

    string flag_name [NFLAGS] = '{"open_flag", "shorted_flag", "overheat_flag"};
    string pulse_name [NFLAGS] = '{"new_open", "new_short", "new_overheat"};

    function automatic t_reading predict_reading(input logic signed [DATA_W-1:0] sample,
                                                 input logic [MASK_W-1:0] mask);
        t_reading          r;
        int                open_hits;
        int                short_hits;
        int                total;
        int                i;
        bit                is_open;
        bit                is_short;
        logic [NFLAGS-1:0] prior;
        sticky_copy = sticky_copy & ~mask;
        prior = sticky_copy;
        ring_copy[slot] = sample;
        r.evaluated = (slot == 0);
        if (slot == 0) begin
            open_hits = 0;
            short_hits = 0;
            total = 0;
            for (i = 0; i < RING; i++) begin
                if (ring_copy[i] == shadow_cfg.open_code) open_hits++;
                if (ring_copy[i] == shadow_cfg.short_code) short_hits++;
                total += ring_copy[i];
            end
            is_open = open_hits >= int'(shadow_cfg.fault_votes);
            is_short = short_hits >= int'(shadow_cfg.fault_votes);
            if (!is_open && !is_short) held_temp = 16'(total / RING);
            if (is_open) begin
                held_temp = shadow_cfg.open_code;
                sticky_copy[FLAG_OPEN] = 1'b1;
            end
            if (is_short) begin
                held_temp = shadow_cfg.short_code;
                sticky_copy[FLAG_SHORT] = 1'b1;
            end
            if (held_temp > shadow_cfg.overheat_limit) sticky_copy[FLAG_HOT] = 1'b1;
        end
        slot = (slot + 1) % RING;
        r.temperature = held_temp;
        r.sticky = sticky_copy;
        r.fresh = sticky_copy & ~prior;
        return r;
    endfunction

    function automatic void add_beat(input logic [15:0] value, input logic [2:0] mask);
        t_script_row row;
        row.kind = ROW_BEAT;
        row.reg_idx = REG_OVERHEAT_LIMIT;
        row.value = value;
        row.mask = mask;
        row.typed = 1'b0;
        row.want = '0;
        script.push_back(row);
    endfunction

    function automatic void add_typed(input logic [15:0] value, input logic [2:0] mask,
                                      input logic [15:0] temp, input logic eval,
                                      input logic [2:0] sticky, input logic [2:0] fresh);
        t_script_row row;
        row.kind = ROW_BEAT;
        row.reg_idx = REG_OVERHEAT_LIMIT;
        row.value = value;
        row.mask = mask;
        row.typed = 1'b1;
        row.want.temperature = temp;
        row.want.evaluated = eval;
        row.want.sticky = sticky;
        row.want.fresh = fresh;
        script.push_back(row);
    endfunction

    function automatic void add_write(input t_reg_idx idx, input logic [15:0] value);
        t_script_row row;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.value = value;
        row.mask = '0;
        row.typed = 1'b0;
        row.want = '0;
        script.push_back(row);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({idx, 2'b00});
        pwdata <= {{(CFG_DATA_W - 16){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OVERHEAT_LIMIT: shadow_cfg.overheat_limit = value;
            REG_OPEN_CODE:      shadow_cfg.open_code = value;
            REG_SHORT_CODE:     shadow_cfg.short_code = value;
            REG_FAULT_VOTES:    shadow_cfg.fault_votes = value[VOTE_W-1:0];
            default: ;
        endcase
        // leave the bus idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic offer_sample(input logic [15:0] sample, input logic [2:0] mask,
                                input bit typed, input t_reading want);
        int       gap;
        t_reading prediction;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_TDATA_W - MASK_W - DATA_W){1'b0}}, mask, sample};
        do @(posedge i_clk); while (!s_axis_tready);
        prediction = predict_reading(sample, mask);
        pending_readings.push_back(typed ? want : prediction);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    // result side: checks every beat, stalls at random, one long hold to back the block up
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            rx_got = t_reading'(m_axis_tdata[$bits(t_reading)-1:0]);
            if (pending_readings.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                rx_want = pending_readings.pop_front();
                check_field("temperature", rx_want.temperature, rx_got.temperature);
                check_field("evaluated", rx_want.evaluated, rx_got.evaluated);
                for (int f = 0; f < NFLAGS; f++) begin
                    check_field(flag_name[f], rx_want.sticky[f], rx_got.sticky[f]);
                    check_field(pulse_name[f], rx_want.fresh[f], rx_got.fresh[f]);
                end
            end
            rx_gap = fill_hold ? FILL_HOLD : (quiet ? 0 : $urandom_range(0, 8));
            fill_hold = 1'b0;
            if (rx_gap > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold = rx_gap;
            end
        end else if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [15:0] s;
        logic [2:0]  m;
        int          p;
        int          b;
        for (int i = 0; i < RING; i++) ring_copy[i] = '0;
        slot = 0;
        held_temp = '0;
        sticky_copy = '0;
        shadow_cfg.overheat_limit = OVERHEAT_RST;
        shadow_cfg.open_code = OPEN_RST;
        shadow_cfg.short_code = SHORT_RST;
        shadow_cfg.fault_votes = VOTES_RST;

        // reset settings: four open and four short entries, short wins
        add_typed(16'h0000, 3'd0, 16'h0000, 1'b1, 3'b000, 3'b000);
        add_typed(16'h7FFF, 3'd0, 16'h0000, 1'b0, 3'b000, 3'b000);
        add_beat(16'h7FFF, 3'd7);
        add_beat(16'h7FFF, 3'd0);
        add_beat(16'h8000, 3'd0);
        add_beat(16'h8000, 3'd0);
        add_beat(16'h8000, 3'd0);
        add_beat(16'h8000, 3'd0);
        add_typed(16'h7FFF, 3'd0, 16'h8000, 1'b1, 3'b011, 3'b011);
        // zero vote count, lowest limit, clear and set on the same beat
        add_write(REG_FAULT_VOTES, 16'd0);
        add_write(REG_OVERHEAT_LIMIT, 16'h8000);
        add_write(REG_OPEN_CODE, 16'd100);
        add_write(REG_SHORT_CODE, 16'hFF9C);
        add_beat(16'h0001, 3'd1);
        add_beat(16'hFFFF, 3'd0);
        add_beat(16'h5555, 3'd2);
        add_beat(16'hAAAA, 3'd0);
        add_beat(16'h0000, 3'd4);
        add_beat(16'h7FFF, 3'd0);
        add_beat(16'h8000, 3'd6);
        add_typed(16'h0007, 3'd7, 16'hFF9C, 1'b1, 3'b111, 3'b111);
        // equal fault codes, full vote, flags already set so no pulses
        add_write(REG_OPEN_CODE, 16'd0);
        add_write(REG_SHORT_CODE, 16'd0);
        add_write(REG_FAULT_VOTES, 16'd8);
        add_write(REG_OVERHEAT_LIMIT, 16'h7FFF);
        for (int i = 0; i < RING - 1; i++) add_beat(16'h0000, 3'd0);
        add_typed(16'h0000, 3'd0, 16'h0000, 1'b1, 3'b111, 3'b000);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                settle_block();
                write_reg(script[k].reg_idx, script[k].value);
            end else begin
                offer_sample(script[k].value, script[k].mask, script[k].typed, script[k].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            settle_block();
            quiet = (p % 3 == 2);
            write_reg(REG_OVERHEAT_LIMIT, pick_code());
            write_reg(REG_OPEN_CODE, pick_code());
            write_reg(REG_SHORT_CODE, ($urandom_range(0, 3) == 0) ? shadow_cfg.open_code
                                                                   : pick_code());
            case ($urandom_range(0, 5))
                0:       write_reg(REG_FAULT_VOTES, 16'd0);
                1:       write_reg(REG_FAULT_VOTES, 16'($urandom_range(9, 15)));
                default: write_reg(REG_FAULT_VOTES, 16'($urandom_range(1, 8)));
            endcase
            for (b = 0; b < PHASE_BEATS; b++) begin
                if (p == 2 && b == 10) fill_hold = 1'b1;
                if (p == 5 && b == 40) settle_block();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s = shadow_cfg.open_code;
                    4, 5, 6:    s = shadow_cfg.short_code;
                    7:          s = 16'($urandom);
                    8:          s = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    default:    s = 16'(int'($urandom_range(0, 4000)) - 2000);
                endcase
                m = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
                offer_sample(s, m, 1'b0, '0);
            end
        end

        settle_block();
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
